// ===== rtl/xrr_pkg.sv =====
// xrr_pkg: shared constants and helper functions for the xorshift range core.
// Holds shift amounts, action codes and the xorshift step; no dependencies.
`default_nettype none

package xrr_pkg;

    localparam int DataW = 32;

    localparam int ShiftA = 13;
    localparam int ShiftB = 17;
    localparam int ShiftC = 5;

    typedef logic [DataW-1:0] word_t;
    typedef logic [1:0]       action_t;

    localparam action_t ACT_RAW      = 2'd0;
    localparam action_t ACT_UNSIGNED = 2'd1;
    localparam action_t ACT_SIGNED   = 2'd2;

    function automatic word_t xorshift_step(input word_t x);
        word_t t;
        t = x ^ (x << ShiftA);
        t = t ^ (t >> ShiftB);
        t = t ^ (t << ShiftC);
        return t;
    endfunction

    // two's complement magnitude; the most negative value maps to 2^31
    function automatic word_t magnitude(input word_t v);
        word_t m;
        m = v[DataW-1] ? (~v + word_t'(1)) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xrr_div.sv =====
// xrr_div: 32-bit restoring remainder unit, one quotient bit per cycle.
// Uses xrr_pkg for widths. A zero divisor returns the dividend unchanged.
`default_nettype none

module xrr_div (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire xrr_pkg::word_t dividend,
    input  wire xrr_pkg::word_t divisor,
    output logic               done,
    output xrr_pkg::word_t     remainder
);

    localparam int CntW = $clog2(xrr_pkg::DataW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    xrr_pkg::word_t  rem_reg, rem_next;
    xrr_pkg::word_t  dvd_reg, dvd_next;
    xrr_pkg::word_t  dsr_reg, dsr_next;

    logic [xrr_pkg::DataW:0] shifted;
    logic [xrr_pkg::DataW:0] diff;
    logic                    fits;

    always_comb begin
        shifted = {rem_reg, dvd_reg[xrr_pkg::DataW-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    // with a zero divisor every step subtracts nothing, so rem collects the dividend
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[xrr_pkg::DataW-1:0] : shifted[xrr_pkg::DataW-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(xrr_pkg::DataW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/xorshift_random_in_range_core.sv =====
// xorshift_random_in_range_core: xorshift32 generator with raw, unsigned and
// signed interval modes. Depends on xrr_pkg and xrr_div.
//
//   Channel  Dir  Handshake           Payload
//   seed     in   seed_wr_en          seed_wr_data
//   s_       in   s_valid / s_ready   s_action, s_low_bound, s_high_bound
//   m_       out  m_valid / m_ready   m_value
//
// A request goes through the load, divide and done states; the 32-step remainder
// unit runs in the divide state. s_ready is high only in the idle state.
// The result waits in an output register, so the next request can be taken
// while m_valid is held against a low m_ready.
// Reset (synchronous, aresetn low) loads the generator with 1.
`default_nettype none

module xorshift_random_in_range_core (
    input  wire logic  aclk,
    input  wire logic  aresetn,

    input  wire logic  seed_wr_en,
    input  wire logic [31:0] seed_wr_data,

    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_low_bound,
    input  wire logic [31:0] s_high_bound,

    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [31:0] m_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    xrr_pkg::word_t   gen_reg, gen_next;
    xrr_pkg::action_t act_reg, act_next;
    xrr_pkg::word_t   lo_reg, lo_next;
    xrr_pkg::word_t   hi_reg, hi_next;
    xrr_pkg::word_t   ofs_reg, ofs_next;
    logic             m_valid_reg, m_valid_next;
    xrr_pkg::word_t   m_value_reg, m_value_next;

    logic             s_xfer;
    logic             out_free;
    logic             div_start;
    xrr_pkg::word_t   div_dividend;
    xrr_pkg::word_t   div_divisor;
    logic             div_done;
    xrr_pkg::word_t   div_rem;
    xrr_pkg::word_t   width;
    logic             b_below_a;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        width     = hi_reg - lo_reg + xrr_pkg::word_t'(1);
        b_below_a = (hi_reg ^ 32'h8000_0000) < (lo_reg ^ 32'h8000_0000);
        case (act_reg)
            xrr_pkg::ACT_UNSIGNED: begin
                div_dividend = gen_reg;
                div_divisor  = width;
                ofs_next     = lo_reg;
            end
            xrr_pkg::ACT_SIGNED: begin
                div_dividend = xrr_pkg::magnitude(gen_reg);
                div_divisor  = xrr_pkg::magnitude(width);
                ofs_next     = b_below_a ? hi_reg : lo_reg;
            end
            default: begin
                // raw: zero divisor passes the value through, no offset
                div_dividend = gen_reg;
                div_divisor  = '0;
                ofs_next     = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_LOAD);

    xrr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        act_next     = act_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    gen_next   = xrr_pkg::xorshift_step(gen_reg);
                    act_next   = s_action;
                    lo_next    = s_low_bound;
                    hi_next    = s_high_bound;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = div_rem + ofs_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (seed_wr_en) begin
            gen_next = seed_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_reg     <= xrr_pkg::word_t'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        m_value_reg <= m_value_next;
        if (state_reg == ST_LOAD) begin
            ofs_reg <= ofs_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    a_xfer_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> state_reg == ST_LOAD)
        else $error("transfer did not start a load");

    a_load_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |=> state_reg == ST_DIV)
        else $error("load did not start the remainder unit");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("remainder done outside of divide state");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== tb/sv/xrr_checker.sv =====
// xrr_checker: watches the request, result and seed ports of the xorshift range core.
// Predicts each result from its own generator copy and compares in order.
// Depends on xrr_pkg for the word and action types, action codes and shift amounts.
`timescale 1ns / 1ps

module xrr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_low_bound,
    input  logic [31:0] s_high_bound,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_value,
    output int          outstanding,
    output int          mismatches
);

    localparam xrr_pkg::word_t SeedAtReset = 32'd1;

    int             errors = 0;
    xrr_pkg::word_t gen_state;
    xrr_pkg::word_t pending_values[$];

    function automatic xrr_pkg::word_t scramble(input xrr_pkg::word_t v);
        xrr_pkg::word_t t;
        t = v ^ (v << xrr_pkg::ShiftA);
        t = t ^ (t >> xrr_pkg::ShiftB);
        t = t ^ (t << xrr_pkg::ShiftC);
        return t;
    endfunction

    function automatic xrr_pkg::word_t predict_value(input xrr_pkg::action_t act,
                                                     input xrr_pkg::word_t x,
                                                     input xrr_pkg::word_t a,
                                                     input xrr_pkg::word_t b);
        xrr_pkg::word_t span, mag_x, mag_span, rem, lower;
        span = b - a + xrr_pkg::word_t'(1);
        case (act)
            xrr_pkg::ACT_UNSIGNED: begin
                rem = (span == '0) ? x : x % span;
                return rem + a;
            end
            xrr_pkg::ACT_SIGNED: begin
                // -2^31 keeps its pattern, which read unsigned is 2^31
                mag_x    = x[31] ? -x : x;
                mag_span = span[31] ? -span : span;
                rem      = (mag_span == '0) ? mag_x : mag_x % mag_span;
                lower    = ($signed(b) < $signed(a)) ? b : a;
                return rem + lower;
            end
            default: return x;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] xrr_checker: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        xrr_pkg::word_t want;
        if (!aresetn) begin
            gen_state = SeedAtReset;
            pending_values.delete();
        end else begin
            if (seed_wr_en) begin
                gen_state = seed_wr_data;
            end
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding",
                                              m_value));
                end else begin
                    want = pending_values.pop_front();
                    if (m_value !== want) begin
                        report_mismatch($sformatf("value %h, expected %h", m_value, want));
                    end
                end
            end
            if (s_valid && s_ready) begin
                gen_state = scramble(gen_state);
                pending_values.push_back(predict_value(s_action, gen_state,
                                                       s_low_bound, s_high_bound));
            end
        end
        outstanding <= pending_values.size();
        mismatches  <= errors;
    end

endmodule

// ===== tb/sv/tb_xorshift_random_in_range_core.sv =====
// tb_xorshift_random_in_range_core: clock, reset, seed writes and request/result traffic
// for xorshift_random_in_range_core; the verdict comes from xrr_checker's mismatch count.
// Depends on xrr_pkg, xrr_checker and the core RTL.
`timescale 1ns / 1ps

module tb_xorshift_random_in_range_core;

    localparam xrr_pkg::action_t ActSpare   = 2'd3;
    localparam int               CycleLimit = 400000;
    localparam int               PhaseCount = 5;
    localparam int               PhaseItems = 106;
    localparam int               LongHold   = 400;
    localparam xrr_pkg::word_t   MostNeg    = 32'h8000_0000;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        seed_wr_en   = 1'b0;
    logic [31:0] seed_wr_data = '0;
    logic        s_valid      = 1'b0;
    logic [1:0]  s_action     = xrr_pkg::ACT_RAW;
    logic [31:0] s_low_bound  = '0;
    logic [31:0] s_high_bound = '0;
    logic        m_ready      = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [31:0] m_value;

    int             outstanding;
    int             mismatches;
    int             delivered = 0;
    int             cycles    = 0;
    bit             quiet     = 1'b0;
    bit             held_long = 1'b0;
    xrr_pkg::word_t corners[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF};
    xrr_pkg::word_t phase_seed[PhaseCount];

    xorshift_random_in_range_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_low_bound  (s_low_bound),
        .s_high_bound (s_high_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

    xrr_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_low_bound  (s_low_bound),
        .s_high_bound (s_high_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            delivered <= delivered + 1;
        end
    end

    // inverts one xorshift stage, left or right
    function automatic xrr_pkg::word_t undo_shift(input xrr_pkg::word_t y, input int k,
                                                  input bit left);
        xrr_pkg::word_t x;
        x = y;
        for (int i = 0; i < 32; i++) begin
            x = left ? (y ^ (x << k)) : (y ^ (x >> k));
        end
        return x;
    endfunction

    task automatic send_request(input xrr_pkg::action_t act, input xrr_pkg::word_t a,
                                input xrr_pkg::word_t b);
        s_valid      <= 1'b1;
        s_action     <= act;
        s_low_bound  <= a;
        s_high_bound <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic settle_and_seed(input xrr_pkg::word_t v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= v;
        @(posedge aclk);
        seed_wr_en <= 1'b0;
    endtask

    task automatic random_request();
        xrr_pkg::action_t act;
        xrr_pkg::word_t   a, b;
        act = ($urandom_range(0, 15) == 0) ? ActSpare
                                           : xrr_pkg::action_t'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0: begin
                a = $urandom;
                b = $urandom;
            end
            1: begin
                a = $urandom;
                b = a + $urandom_range(0, 64);
            end
            2: begin
                a = xrr_pkg::word_t'($urandom_range(0, 2000)) - 1000;
                b = a + $urandom_range(0, 500);
            end
            3: begin
                b = xrr_pkg::word_t'($urandom_range(0, 2000)) - 1000;
                a = b + $urandom_range(0, 500);
            end
            4: begin
                a = corners[$urandom_range(0, 3)];
                b = corners[$urandom_range(0, 3)];
            end
            default: begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
        endcase
        send_request(act, a, b);
    endtask

    // receiver: random stalls, one long hold-off, none at the end
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && !held_long && delivered >= 150) begin
                m_ready <= 1'b0;
                repeat (LongHold) @(posedge aclk);
                held_long = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        phase_seed[0] = 32'hFFFF_FFFF;
        phase_seed[1] = $urandom;
        phase_seed[2] = 32'h0000_0001;
        phase_seed[3] = $urandom;
        phase_seed[4] = $urandom;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // generator from reset
        send_request(xrr_pkg::ACT_RAW,      32'h0000_0000, 32'h0000_0000);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'hFFFF_FFF0, 32'h0000_000F);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'd1000,      32'd10);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(xrr_pkg::ACT_SIGNED,   32'h8000_0000, 32'h7FFF_FFFF);
        send_request(xrr_pkg::ACT_SIGNED,   32'h0000_0000, 32'h7FFF_FFFF);
        send_request(xrr_pkg::ACT_SIGNED,   32'd100,       -32'd100);
        send_request(xrr_pkg::ACT_SIGNED,   -32'd50,       -32'd50);
        send_request(xrr_pkg::ACT_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000);
        send_request(ActSpare,              32'hFFFF_FFFF, 32'h0000_0000);
        send_request(xrr_pkg::ACT_RAW,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(xrr_pkg::ACT_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000);

        // next generator value is -2^31
        settle_and_seed(undo_shift(undo_shift(undo_shift(MostNeg, xrr_pkg::ShiftC, 1'b1),
                                              xrr_pkg::ShiftB, 1'b0),
                                   xrr_pkg::ShiftA, 1'b1));
        send_request(xrr_pkg::ACT_SIGNED, -32'd7, 32'd20);
        send_request(xrr_pkg::ACT_RAW,    32'd0,  32'd0);

        // zero seed sticks at zero
        settle_and_seed(32'h0000_0000);
        send_request(xrr_pkg::ACT_RAW,      32'd0,  32'd0);
        send_request(xrr_pkg::ACT_UNSIGNED, 32'd3,  32'd9);
        send_request(xrr_pkg::ACT_SIGNED,   -32'd5, 32'd5);

        for (int p = 0; p < PhaseCount; p++) begin
            settle_and_seed(phase_seed[p]);
            quiet = (p == PhaseCount - 1);
            repeat (PhaseItems) random_request();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
